[hdl/taflag_pkg.sv]
// ----------------------------------------------------------------------------
// taflag_pkg
// Shared types, request codes and helpers for the thumb alu flag-setting core
// ----------------------------------------------------------------------------
package taflag_pkg;

    localparam int DataW          = 32;
    localparam int IdxFieldW      = 4;
    localparam int NumRegsDefault = 16;
    localparam int ShiftAmtW      = 8;

    // request codes carried in s_tuser
    typedef enum logic [2:0] {
        REQ_LOAD = 3'd0,
        REQ_ANDS = 3'd1,
        REQ_ADCS = 3'd2,
        REQ_ADDS = 3'd3,
        REQ_BICS = 3'd4,
        REQ_LSLS = 3'd5,
        REQ_ASRS = 3'd6,
        REQ_NOP  = 3'd7
    } req_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    // register index wrap, a few conditional subtracts on a 4-bit value
    function automatic logic [IdxFieldW-1:0] wrap_idx(
        input logic [IdxFieldW-1:0] idx,
        input logic [IdxFieldW:0]   n
    );
        logic [IdxFieldW:0] v;
        v = {1'b0, idx};
        for (int k = 0; k < 8; k++) begin
            if (v >= n) begin
                v = v - n;
            end
        end
        return v[IdxFieldW-1:0];
    endfunction

endpackage

[hdl/taflag_ram.sv]
// ----------------------------------------------------------------------------
// taflag_ram
// Generic RAM, one write port and two registered read ports
// ----------------------------------------------------------------------------
module taflag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a_reg <= mem[rd_addr_a];
            rd_data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

[hdl/thumb_alu_flag_setting_ops_core.sv]
// ----------------------------------------------------------------------------
// thumb_alu_flag_setting_ops_core
// Thumb style alu with register file and nzcv flags: load, ands, adcs, adds,
// bics, lsls, asrs; the alu ops as rd = rd op rm, load as rd = load value; returning result and flags
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser: req_type; s_tdata: dest, src, load
//  m_      | out | m_tvalid/m_tready  | m_tdata: result_value, n, z, c, v
//
//  one request per cycle sustained unless m_tready stalls; an accepted request reaches m_tvalid
//  through the operand read from the register file ram, then alu into the result register
//  the last write is forwarded so back-to-back dependent requests run at full rate
//  aresetn (synchronous, active low) clears the flags, the valid bits and the
//  pipeline; registers never written read as zero through per-entry valid bits
//  a stall on m_tready holds the request in the operand stage; s_tready drops
//  only when both stages are full
// ----------------------------------------------------------------------------
module thumb_alu_flag_setting_ops_core
    import taflag_pkg::*;
#(
    parameter int NUM_REGS = NumRegsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // dest_index[3:0], src_index[7:4], load_value[39:8]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // result_value[31:0], n[32], z[33], c[34], v[35], zero pad
);

    localparam int IdxW = $clog2(NUM_REGS);

    // incoming fields
    logic [IdxFieldW-1:0] s_dest_raw;
    logic [IdxFieldW-1:0] s_src_raw;
    logic [IdxW-1:0]      s_dest;
    logic [IdxW-1:0]      s_src;
    logic                 s_accept;

    // operand stage
    logic                 in_valid_reg;
    logic                 in_valid_next;
    req_t                 req_reg;
    logic [IdxW-1:0]      dest_reg;
    logic [IdxW-1:0]      src_reg;
    logic [DataW-1:0]     load_reg;
    logic                 a_known_reg;
    logic                 b_known_reg;
    logic                 stage_fire;

    // register file and its valid bits
    logic [NUM_REGS-1:0]  known_reg;
    logic [DataW-1:0]     ram_a;
    logic [DataW-1:0]     ram_b;

    // newest write, forwarded over the ram read
    logic                 fwd_valid_reg;
    logic [IdxW-1:0]      fwd_addr_reg;
    logic [DataW-1:0]     fwd_data_reg;

    // alu
    logic [DataW-1:0]     op_a;
    logic [DataW-1:0]     op_b;
    logic [ShiftAmtW-1:0] amt;
    logic                 cin;
    logic [DataW:0]       sum_wide;
    logic [DataW:0]       lsl_wide;
    logic [DataW:0]       asr_wide;
    logic [5:0]           asr_sh;
    logic [DataW-1:0]     res_next;
    flags_t               flags_reg;
    flags_t               flags_next;

    // result stage
    logic                 out_valid_reg;
    logic [DataW-1:0]     result_reg;

    assign s_dest_raw = s_tdata[3:0];
    assign s_src_raw  = s_tdata[7:4];
    assign s_dest     = IdxW'(wrap_idx(s_dest_raw, 5'(NUM_REGS)));
    assign s_src      = IdxW'(wrap_idx(s_src_raw, 5'(NUM_REGS)));

    assign stage_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || stage_fire;
    assign s_accept   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (stage_fire) begin
            in_valid_next = 1'b0;
        end
    end

    taflag_ram #(
        .WIDTH (DataW),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .aclk      (aclk),
        .wr_en     (stage_fire),
        .wr_addr   (dest_reg),
        .wr_data   (res_next),
        .rd_en     (s_accept),
        .rd_addr_a (s_dest),
        .rd_addr_b (s_src),
        .rd_data_a (ram_a),
        .rd_data_b (ram_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            known_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (stage_fire) begin
                out_valid_reg       <= 1'b1;
                known_reg[dest_reg] <= 1'b1;
                fwd_valid_reg       <= 1'b1;
                flags_reg           <= flags_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg     <= req_t'(s_tuser);
            dest_reg    <= s_dest;
            src_reg     <= s_src;
            load_reg    <= s_tdata[39:8];
            a_known_reg <= known_reg[s_dest];
            b_known_reg <= known_reg[s_src];
        end
        if (stage_fire) begin
            fwd_addr_reg <= dest_reg;
            fwd_data_reg <= res_next;
            result_reg   <= res_next;
        end
    end

    // operand select: newest write wins, then ram, then zero for never written
    always_comb begin
        if (fwd_valid_reg && fwd_addr_reg == dest_reg) begin
            op_a = fwd_data_reg;
        end else begin
            op_a = a_known_reg ? ram_a : '0;
        end
        if (fwd_valid_reg && fwd_addr_reg == src_reg) begin
            op_b = fwd_data_reg;
        end else begin
            op_b = b_known_reg ? ram_b : '0;
        end
    end

    assign amt      = op_b[ShiftAmtW-1:0];
    assign cin      = (req_reg == REQ_ADCS) ? flags_reg.c : 1'b0;
    assign sum_wide = {1'b0, op_a} + {1'b0, op_b} + {{DataW{1'b0}}, cin};
    // bit 32 is the last bit shifted out for amounts up to 32
    assign lsl_wide = {1'b0, op_a} << amt[5:0];
    assign asr_sh   = (amt >= 8'd32) ? 6'd32 : amt[5:0];
    // bit 0 is the last bit shifted out, sign fills from 32 on
    assign asr_wide = ($signed({op_a, 1'b0}) >>> asr_sh);

    always_comb begin
        res_next   = op_a;
        flags_next = flags_reg;
        case (req_reg)
            REQ_LOAD: begin
                res_next = load_reg;
            end
            REQ_ANDS: begin
                res_next = op_a & op_b;
            end
            REQ_BICS: begin
                res_next = op_a & ~op_b;
            end
            REQ_ADCS, REQ_ADDS: begin
                res_next     = sum_wide[DataW-1:0];
                flags_next.c = sum_wide[DataW];
                flags_next.v = (op_a[DataW-1] == op_b[DataW-1]) &&
                               (sum_wide[DataW-1] != op_a[DataW-1]);
            end
            REQ_LSLS: begin
                if (amt == 8'd0) begin
                    res_next = op_a;
                end else if (amt <= 8'd32) begin
                    res_next     = lsl_wide[DataW-1:0];
                    flags_next.c = lsl_wide[DataW];
                end else begin
                    res_next     = '0;
                    flags_next.c = 1'b0;
                end
            end
            REQ_ASRS: begin
                if (amt == 8'd0) begin
                    res_next = op_a;
                end else begin
                    res_next     = asr_wide[DataW:1];
                    flags_next.c = asr_wide[0];
                end
            end
            default: begin
                res_next = op_a;
            end
        endcase
        if (req_reg != REQ_LOAD && req_reg != REQ_NOP) begin
            flags_next.n = res_next[DataW-1];
            flags_next.z = (res_next == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, flags_reg.v, flags_reg.c, flags_reg.z, flags_reg.n, result_reg};

    // stalled request stays put in the operand stage
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !stage_fire |=> in_valid_reg && $stable(dest_reg) && $stable(req_reg))
        else $error("operand stage changed while stalled");

    // a load never touches the flags
    a_load_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_fire && req_reg == REQ_LOAD |=> $stable(flags_reg))
        else $error("load changed flags");

    // logical ops keep carry and overflow
    a_logic_cv: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_fire && (req_reg == REQ_ANDS || req_reg == REQ_BICS)
        |=> flags_reg.c == $past(flags_reg.c) && flags_reg.v == $past(flags_reg.v))
        else $error("logical op changed c or v");

    // zero shift amount keeps carry and overflow
    a_shift_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_fire && (req_reg == REQ_LSLS || req_reg == REQ_ASRS) && amt == 8'd0
        |=> flags_reg.c == $past(flags_reg.c) && flags_reg.v == $past(flags_reg.v))
        else $error("zero shift changed c or v");

endmodule

[tb/thumb_alu_flag_setting_ops_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb_alu_flag_setting_ops_checker
// Watches both channels of the thumb alu core, runs every accepted request
// against a shadow register file and nzcv word, and compares each returned
// result field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module thumb_alu_flag_setting_ops_checker
    import taflag_pkg::*;
#(
    parameter int NUM_REGS = NumRegsDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // dest_index[3:0], src_index[7:4], load_value[39:8]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // result_value[31:0], n[32], z[33], c[34], v[35], zero pad
    output int          error_count,
    output int          pending_count,
    output int          checked_count
);

    typedef struct packed {
        logic [DataW-1:0] value;
        flags_t           flags;
    } alu_result_t;

    logic [DataW-1:0] shadow_regs [NUM_REGS];
    flags_t           shadow_nzcv;
    alu_result_t      expected_results [$];

    // executes one request on the shadow state and returns what the core should send
    function automatic alu_result_t execute_request(
        input req_t             kind,
        input logic [3:0]       dest_raw,
        input logic [3:0]       src_raw,
        input logic [DataW-1:0] load_value
    );
        int               d;
        int               s;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic [DataW-1:0] r;
        logic [DataW:0]   wide;
        logic [7:0]       amt;
        flags_t           f;
        alu_result_t      res;
        d    = int'(dest_raw) % NUM_REGS;
        s    = int'(src_raw) % NUM_REGS;
        a    = shadow_regs[d];
        b    = shadow_regs[s];
        f    = shadow_nzcv;
        r    = a;
        amt  = b[7:0];
        case (kind)
            REQ_LOAD: begin
                r = load_value;
            end
            REQ_ANDS: begin
                r = a & b;
            end
            REQ_BICS: begin
                r = a & ~b;
            end
            REQ_ADCS, REQ_ADDS: begin
                wide = {1'b0, a} + {1'b0, b} + ((kind == REQ_ADCS && f.c) ? 33'd1 : 33'd0);
                r    = wide[DataW-1:0];
                f.c  = wide[DataW];
                f.v  = (a[31] == b[31]) && (r[31] != a[31]);
            end
            REQ_LSLS: begin
                if (amt == 8'd0) begin
                    r = a;
                end else if (amt < 8'd32) begin
                    r   = a << amt;
                    f.c = a[32 - int'(amt)];
                end else if (amt == 8'd32) begin
                    r   = '0;
                    f.c = a[0];
                end else begin
                    r   = '0;
                    f.c = 1'b0;
                end
            end
            REQ_ASRS: begin
                if (amt == 8'd0) begin
                    r = a;
                end else if (amt < 8'd32) begin
                    r   = $signed(a) >>> amt;
                    f.c = a[int'(amt) - 1];
                end else begin
                    r   = {DataW{a[31]}};
                    f.c = a[31];
                end
            end
            default: begin
                r = a;
            end
        endcase
        // every flag-setting operation refreshes n and z from its result
        if (kind != REQ_LOAD && kind != REQ_NOP) begin
            f.n = r[31];
            f.z = (r == '0);
        end
        shadow_regs[d] = r;
        shadow_nzcv    = f;
        res.value      = r;
        res.flags      = f;
        return res;
    endfunction

    function automatic void compare_field(
        input string       field_name,
        input logic [31:0] exp_val,
        input logic [31:0] act_val
    );
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h",
                     $time, field_name, exp_val, act_val);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        alu_result_t exp_res;
        if (!aresetn) begin
            foreach (shadow_regs[i]) begin
                shadow_regs[i] = '0;
            end
            shadow_nzcv = '0;
            expected_results.delete();
            error_count   = 0;
            pending_count = 0;
            checked_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(execute_request(req_t'(s_tuser), s_tdata[3:0],
                                                           s_tdata[7:4], s_tdata[39:8]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result %h with no request outstanding", $time, m_tdata);
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    compare_field("result_value",  exp_res.value,   m_tdata[31:0]);
                    compare_field("flag_negative", exp_res.flags.n, m_tdata[32]);
                    compare_field("flag_zero",     exp_res.flags.z, m_tdata[33]);
                    compare_field("flag_carry",    exp_res.flags.c, m_tdata[34]);
                    compare_field("flag_overflow", exp_res.flags.v, m_tdata[35]);
                    checked_count++;
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

[tb/thumb_alu_flag_setting_ops_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb_alu_flag_setting_ops_core_test
// Drives loads and flag-setting alu requests into the core with random gaps
// and result back-pressure, including a long receiver hold-off; the checker
// beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module thumb_alu_flag_setting_ops_core_test;
    import taflag_pkg::*;

    localparam int IdleLimit = 2000;
    localparam int HoldCycles = 80;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // dest_index[3:0], src_index[7:4], load_value[39:8]
    logic [2:0]  s_tuser;   // req_type[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // result_value[31:0], n[32], z[33], c[34], v[35], zero pad

    int error_count;
    int pending_count;
    int checked_count;
    int idle_cycles;
    int kind_count [8];
    bit src_gaps_en;
    bit sink_stalls_en;
    bit hold_toggle;

    thumb_alu_flag_setting_ops_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    thumb_alu_flag_setting_ops_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    // words that hit flag corners and shift amounts around 0, 31, 32, 33
    function automatic logic [31:0] pick_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return {w[31:8], 8'($urandom_range(0, 40))};
            5: return 32'($urandom_range(0, 40));
            6: return {w[31:8], 8'($urandom_range(0, 255))};
            default: return w;
        endcase
    endfunction

    // starts and ends at a falling edge; valid stays up across back-to-back requests
    task automatic send_request(
        input req_t        kind,
        input logic [3:0]  dest_idx,
        input logic [3:0]  src_idx,
        input logic [31:0] load_value
    );
        int gap;
        gap = src_gaps_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {load_value, src_idx, dest_idx};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        kind_count[int'(kind)]++;
        @(negedge aclk);
    endtask

    task automatic send_random(input int count);
        int   roll;
        req_t kind;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                kind = REQ_LOAD;
            end else if (roll < 97) begin
                kind = req_t'($urandom_range(int'(REQ_ANDS), int'(REQ_ASRS)));
            end else begin
                kind = REQ_NOP;
            end
            send_request(kind, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         (kind == REQ_LOAD) ? pick_word() : 32'($urandom()));
        end
    endtask

    // stop offering so the last request is not taken again while draining
    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (pending_count != 0) begin
            @(negedge aclk);
        end
    endtask

    // result side back-pressure, plus a long hold-off each time hold_toggle flips
    initial begin
        int stall_left;
        int hold_left;
        bit seen_toggle;
        stall_left  = 0;
        hold_left   = 0;
        seen_toggle = 1'b0;
        m_tready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (seen_toggle != hold_toggle) begin
                seen_toggle = hold_toggle;
                hold_left   = HoldCycles;
            end
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else if (sink_stalls_en && $urandom_range(0, 99) < 30) begin
                m_tready   = 1'b0;
                stall_left = pick_gap();
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IdleLimit) begin
                $display("%0t: no channel activity for %0d cycles, %0d results outstanding",
                         $time, IdleLimit, pending_count);
                $display("** thumb_alu_flag_setting_ops_core: FAILED **");
                $finish;
            end
        end
    end

    initial begin
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = REQ_LOAD;
        aresetn        = 1'b0;
        src_gaps_en    = 1'b1;
        sink_stalls_en = 1'b1;
        hold_toggle    = 1'b0;
        foreach (kind_count[i]) begin
            kind_count[i] = 0;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed corners
        send_request(REQ_LOAD, 4'd0,  4'd0,  32'h8000_0000);
        send_request(REQ_LOAD, 4'd2,  4'd0,  32'hFFFF_FFFF);
        send_request(REQ_LOAD, 4'd4,  4'd0,  32'd32);
        send_request(REQ_LOAD, 4'd5,  4'd0,  32'd33);
        send_request(REQ_LOAD, 4'd7,  4'd0,  32'h0000_0100);
        send_request(REQ_LOAD, 4'd8,  4'd0,  32'd31);
        send_request(REQ_LOAD, 4'd6,  4'd0,  32'd1);
        send_request(REQ_LOAD, 4'd9,  4'd0,  32'h7FFF_FFFF);
        send_request(REQ_ADDS, 4'd9,  4'd6,  32'h0);   // signed overflow into n
        send_request(REQ_ADDS, 4'd2,  4'd6,  32'h0);   // wraps to zero with carry
        send_request(REQ_ADCS, 4'd9,  4'd2,  32'h0);   // carry in from c
        send_request(REQ_LOAD, 4'd10, 4'd0,  32'h8000_0001);
        send_request(REQ_LSLS, 4'd10, 4'd4,  32'h0);   // shift by exactly 32
        send_request(REQ_LSLS, 4'd9,  4'd5,  32'h0);   // shift beyond 32 clears c
        send_request(REQ_LOAD, 4'd11, 4'd0,  32'h8000_0000);
        send_request(REQ_ASRS, 4'd11, 4'd4,  32'h0);   // sign fill
        send_request(REQ_ASRS, 4'd0,  4'd8,  32'h0);   // shift by 31
        send_request(REQ_LSLS, 4'd6,  4'd7,  32'h0);   // low byte zero keeps c
        send_request(REQ_ANDS, 4'd9,  4'd0,  32'h0);
        send_request(REQ_BICS, 4'd0,  4'd2,  32'h0);
        send_request(REQ_ASRS, 4'd6,  4'd6,  32'h0);   // same register as amount
        send_request(REQ_LOAD, 4'd15, 4'd0,  32'hA5A5_A5A5);
        send_request(REQ_ANDS, 4'd15, 4'd15, 32'h5A5A_5A5A);
        send_request(REQ_NOP,  4'd0,  4'd15, 32'hFFFF_FFFF);

        send_random(600);

        // full rate on both sides
        src_gaps_en    = 1'b0;
        sink_stalls_en = 1'b0;
        send_random(300);

        // receiver hold-off while requests keep coming, then pause until drained
        hold_toggle = ~hold_toggle;
        send_random(40);
        wait_results_drained();

        src_gaps_en    = 1'b1;
        sink_stalls_en = 1'b1;
        send_random(400);

        src_gaps_en = 1'b0;
        hold_toggle = ~hold_toggle;
        send_random(30);
        src_gaps_en = 1'b1;
        send_random(380);

        s_tvalid = 1'b0;
        wait_results_drained();
        repeat (16) @(posedge aclk);

        $display("sent %0d loads, %0d ands, %0d adcs, %0d adds,",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
        $display("     %0d bics, %0d lsls, %0d asrs, %0d nop",
                 kind_count[4], kind_count[5], kind_count[6], kind_count[7]);
        $display("%0d results compared across gapped, full rate and held-off phases",
                 checked_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("** thumb_alu_flag_setting_ops_core: PASSED **");
        end else begin
            $display("** thumb_alu_flag_setting_ops_core: FAILED **");
        end
        $finish;
    end

endmodule
